/* design/dat_pkg.sv */
// Package with shared types and constants of the delayed action timer table.
package dat_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned MaxFired = 16;
  localparam int unsigned CountMax = 31;

  typedef enum logic [2:0] {
    KindAdd       = 3'd0,
    KindTick      = 3'd1,
    KindCancelHdl = 3'd2,
    KindCancelOwn = 3'd3,
    KindQuery     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StExec,
    StEmit,
    StDone
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_us;
    logic [31:0] delay_amount;
    logic        repeat_req;
    logic        frame_based;
    logic [7:0]  owner_id;
    logic [31:0] target_handle;
  } req_t;

  typedef struct packed {
    logic [31:0] out_handle;
    logic        fired;
    logic        ok;
    logic [4:0]  cancel_count;
    logic        last;
  } rsp_t;

endpackage

/* design/dat_stream_if.sv */
// Valid/ready channel interface that carries one payload item per transfer.
interface dat_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/delayed_action_timer_table.sv */
// Top level of the delayed action timer table with its slot memory and sequencer.
//
// Requests arrive on req_i (add, tick, cancel by handle, cancel by owner,
// query) and results leave on rsp_o; a transfer happens when valid and ready
// are both high. Every request yields one result with last set, except a
// tick, which yields one result per fired timer in slot order, up to
// MaxFired of them, and then a closing result with last set.
// The sequencer walks the slots one at a time through a single memory port:
// each slot is read, then updated. An add stops at the first free slot.
// One request is in work at a time; req_i.ready is low until the final
// result has been transferred.
// Results sit in an output register; when the receiver stalls, the walk
// waits there and no state changes until the result is taken.
// Reset clears the live bits and sets the next handle to one; the slot
// contents need no clearing, since they are read only while live.
module delayed_action_timer_table #(
  parameter int unsigned SLOTS = dat_pkg::SlotsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dat_stream_if.sink   req_i,
  dat_stream_if.source rsp_o
);
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [31:0] handle;
    logic [7:0]  owner;
    logic        rep;
    logic        frame;
    logic [31:0] delay;
    logic [31:0] accum;
    logic [31:0] last_time;
  } slot_t;

  slot_t mem_q [SLOTS];
  slot_t rd_q;
  logic [SLOTS-1:0] live_q, live_d;
  logic [31:0] next_handle_q, next_handle_d;
  dat_pkg::state_e state_q, state_d;
  dat_pkg::req_t req_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] idx;
  logic [4:0] cnt_q, cnt_d;
  logic [CntW-1:0] nfired_q, nfired_d;
  logic hit_q, hit_d;
  dat_pkg::rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;
  logic wr_en;
  slot_t wr_data;
  logic [32:0] sum;
  logic [31:0] accum_sat, addend;
  logic fire;
  logic slot_live;

  assign idx = idx_q[IdxW-1:0];
  assign slot_live = live_q[idx];

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx] <= wr_data;
    end
    rd_q <= mem_q[idx];
  end

  // Shared adder: frame timers add one, time timers add the elapsed time.
  assign addend = rd_q.frame ? 32'd1 : (req_q.now_us - rd_q.last_time);
  assign sum = {1'b0, rd_q.accum} + {1'b0, addend};
  assign accum_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign fire = accum_sat >= rd_q.delay;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dat_pkg::StIdle: if (req_i.valid) state_d = dat_pkg::StRead;
      dat_pkg::StRead: begin
        if (idx_q == CntW'(SLOTS)) begin
          state_d = dat_pkg::StDone;
        end else begin
          state_d = dat_pkg::StExec;
        end
      end
      dat_pkg::StExec: begin
        if (req_q.kind == dat_pkg::KindAdd && !slot_live) begin
          state_d = dat_pkg::StDone;
        end else if (req_q.kind == dat_pkg::KindCancelHdl && slot_live &&
                     rd_q.handle == req_q.target_handle) begin
          state_d = dat_pkg::StDone;
        end else if (req_q.kind == dat_pkg::KindTick && slot_live && fire &&
                     nfired_q < CntW'(dat_pkg::MaxFired)) begin
          state_d = dat_pkg::StEmit;
        end else if (req_q.kind == dat_pkg::KindTick ||
                     req_q.kind == dat_pkg::KindAdd ||
                     req_q.kind == dat_pkg::KindCancelHdl ||
                     req_q.kind == dat_pkg::KindCancelOwn ||
                     req_q.kind == dat_pkg::KindQuery) begin
          state_d = dat_pkg::StRead;
        end else begin
          state_d = dat_pkg::StDone;
        end
      end
      dat_pkg::StEmit: if (rsp_valid_q && rsp_o.ready) state_d = dat_pkg::StRead;
      dat_pkg::StDone: if (rsp_valid_q && rsp_o.ready) state_d = dat_pkg::StIdle;
      default: state_d = dat_pkg::StIdle;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    live_d = live_q;
    next_handle_d = next_handle_q;
    cnt_d = cnt_q;
    nfired_d = nfired_q;
    hit_d = hit_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q;
    wr_en = 1'b0;
    wr_data = rd_q;
    req_i.ready = 1'b0;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    unique case (state_q)
      dat_pkg::StIdle: begin
        req_i.ready = 1'b1;
        idx_d = '0;
        cnt_d = '0;
        nfired_d = '0;
        hit_d = 1'b0;
      end
      dat_pkg::StRead: begin
        if (idx_q == CntW'(SLOTS)) begin
          // Walk finished without an early stop: closing result.
          rsp_d = '0;
          rsp_d.last = 1'b1;
          rsp_d.ok = hit_q;
          rsp_d.cancel_count = cnt_q;
          rsp_valid_d = 1'b1;
        end
      end
      dat_pkg::StExec: begin
        idx_d = idx_q + 1'b1;
        unique case (req_q.kind)
          dat_pkg::KindAdd: if (!slot_live) begin
            wr_en = 1'b1;
            wr_data.handle = next_handle_q;
            wr_data.owner = req_q.owner_id;
            wr_data.rep = req_q.repeat_req;
            wr_data.frame = req_q.frame_based;
            wr_data.delay = req_q.delay_amount;
            wr_data.accum = '0;
            wr_data.last_time = req_q.now_us;
            live_d[idx] = 1'b1;
            next_handle_d = next_handle_q + 32'd1;
            rsp_d = '0;
            rsp_d.out_handle = next_handle_q;
            rsp_d.ok = 1'b1;
            rsp_d.last = 1'b1;
            rsp_valid_d = 1'b1;
          end
          dat_pkg::KindTick: if (slot_live) begin
            wr_en = 1'b1;
            if (rd_q.frame) begin
              wr_data.accum = fire ? 32'd0 : accum_sat;
            end else begin
              wr_data.accum = fire ? accum_sat - rd_q.delay : accum_sat;
              wr_data.last_time = req_q.now_us;
            end
            if (fire) begin
              if (!rd_q.rep) live_d[idx] = 1'b0;
              if (nfired_q < CntW'(dat_pkg::MaxFired)) begin
                nfired_d = nfired_q + 1'b1;
                rsp_d = '0;
                rsp_d.out_handle = rd_q.handle;
                rsp_d.fired = 1'b1;
                rsp_valid_d = 1'b1;
              end
            end
          end
          dat_pkg::KindCancelHdl: begin
            if (slot_live && rd_q.handle == req_q.target_handle) begin
              live_d[idx] = 1'b0;
              rsp_d = '0;
              rsp_d.ok = 1'b1;
              rsp_d.cancel_count = 5'd1;
              rsp_d.last = 1'b1;
              rsp_valid_d = 1'b1;
            end
          end
          dat_pkg::KindCancelOwn: begin
            if (slot_live && req_q.owner_id != 8'd0 && rd_q.owner == req_q.owner_id) begin
              live_d[idx] = 1'b0;
              if (cnt_q != 5'(dat_pkg::CountMax)) cnt_d = cnt_q + 5'd1;
            end
          end
          dat_pkg::KindQuery: begin
            if (slot_live && rd_q.handle == req_q.target_handle) hit_d = 1'b1;
          end
          default: begin
            rsp_d = '0;
            rsp_d.last = 1'b1;
            rsp_valid_d = 1'b1;
          end
        endcase
      end
      dat_pkg::StEmit, dat_pkg::StDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dat_pkg::StIdle;
      live_q <= '0;
      next_handle_q <= 32'd1;
      rsp_valid_q <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
      nfired_q <= '0;
      hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q <= live_d;
      next_handle_q <= next_handle_d;
      rsp_valid_q <= rsp_valid_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      nfired_q <= nfired_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (req_i.valid && req_i.ready) req_q <= req_i.data;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data = rsp_q;

`ifndef NO_ASSERTIONS
  // A result is only pending while waiting in an emit or done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (state_q == dat_pkg::StEmit || state_q == dat_pkg::StDone))
    else $error("result pending outside emit or done");
  // The next handle only moves on a successful add.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_handle_q != $past(next_handle_q)) |-> ($past(state_q) == dat_pkg::StExec &&
      $past(req_q.kind) == dat_pkg::KindAdd))
    else $error("next handle changed outside add");
  // Fired results never exceed the per-tick limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfired_q <= CntW'(dat_pkg::MaxFired))
    else $error("fired count over limit");
`endif
endmodule
